// ===== sv/qrt_pkg.sv =====
// Shared constants, types and width helpers for the quaternion rigid transform.
`timescale 1ns / 1ps
`default_nettype none

package qrt_pkg;

    // Default quaternion fraction bits (Q2.14)
    localparam int QUAT_FRAC_BITS_DEF = 14;

    // Fixed field widths
    localparam int COORD_W = 32;
    localparam int QUAT_W  = 16;
    localparam int VEC_W   = COORD_W + 1;  // point minus position, exact
    localparam int UVEC_W  = QUAT_W + 1;   // negated quaternion part, exact
    localparam int ADDR_W  = 5;
    localparam int DATA_W  = 32;

    // Opcodes
    localparam logic OP_FORWARD = 1'b0;
    localparam logic OP_INVERSE = 1'b1;

    // Register indexes (byte address / 4)
    typedef enum logic [2:0] {
        REG_POS_X,
        REG_POS_Y,
        REG_POS_Z,
        REG_QUAT_W,
        REG_QUAT_X,
        REG_QUAT_Y,
        REG_QUAT_Z
    } reg_idx_t;

    // Pose registers as seen by the datapath
    typedef struct packed {
        logic [COORD_W-1:0] pos_x;
        logic [COORD_W-1:0] pos_y;
        logic [COORD_W-1:0] pos_z;
        logic [DATA_W-1:0]  quat_w;
        logic [QUAT_W-1:0]  quat_x;
        logic [QUAT_W-1:0]  quat_y;
        logic [QUAT_W-1:0]  quat_z;
    } cfg_t;

    // Scalar part width: must hold the reset value 1.0 at any fraction width
    function automatic int quat_w_width(input int qf);
        return (qf + 2 > QUAT_W) ? qf + 2 : QUAT_W;
    endfunction

    // Width of the rounded vector t = 2 (u x v)
    function automatic int t_width(input int qf);
        return UVEC_W + VEC_W + 3 - qf;
    endfunction

    // Width of the second multiplier rank operand (scalar or vector part)
    function automatic int mul2_width(input int qf);
        return (quat_w_width(qf) > UVEC_W) ? quat_w_width(qf) : UVEC_W;
    endfunction

    // Width of the rotated-and-translated result before clipping
    function automatic int out_width(input int qf);
        int rw;
        begin
            rw = mul2_width(qf) + t_width(qf) + 3 - qf;
            return ((rw > VEC_W) ? rw : VEC_W) + 2;
        end
    endfunction

endpackage

`default_nettype wire

// ===== sv/qrt_regs.sv =====
// APB register file holding the pose: translation and quaternion.
`timescale 1ns / 1ps
`default_nettype none

module qrt_regs #(
    parameter int QUAT_FRAC_BITS = qrt_pkg::QUAT_FRAC_BITS_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [qrt_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [qrt_pkg::DATA_W-1:0]  pwdata,
    output logic      [qrt_pkg::DATA_W-1:0]  prdata,
    output logic                             pready,
    output qrt_pkg::cfg_t                    cfg
);

    localparam int QW = qrt_pkg::quat_w_width(QUAT_FRAC_BITS);
    localparam logic [QW-1:0] QUAT_ONE = QW'(1) << QUAT_FRAC_BITS;

    logic [qrt_pkg::COORD_W-1:0] pos_x_reg, pos_x_next;
    logic [qrt_pkg::COORD_W-1:0] pos_y_reg, pos_y_next;
    logic [qrt_pkg::COORD_W-1:0] pos_z_reg, pos_z_next;
    logic [QW-1:0]               quat_w_reg, quat_w_next;
    logic [qrt_pkg::QUAT_W-1:0]  quat_x_reg, quat_x_next;
    logic [qrt_pkg::QUAT_W-1:0]  quat_y_reg, quat_y_next;
    logic [qrt_pkg::QUAT_W-1:0]  quat_z_reg, quat_z_next;

    logic               wr_en;
    qrt_pkg::reg_idx_t  idx;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;
    assign idx    = qrt_pkg::reg_idx_t'(paddr[qrt_pkg::ADDR_W-1:2]);

    // Decode the write
    always_comb
    begin
        pos_x_next  = pos_x_reg;
        pos_y_next  = pos_y_reg;
        pos_z_next  = pos_z_reg;
        quat_w_next = quat_w_reg;
        quat_x_next = quat_x_reg;
        quat_y_next = quat_y_reg;
        quat_z_next = quat_z_reg;
        if (wr_en)
        begin
            case (idx)
                qrt_pkg::REG_POS_X:  pos_x_next  = pwdata;
                qrt_pkg::REG_POS_Y:  pos_y_next  = pwdata;
                qrt_pkg::REG_POS_Z:  pos_z_next  = pwdata;
                qrt_pkg::REG_QUAT_W: quat_w_next = QW'($signed(pwdata[qrt_pkg::QUAT_W-1:0]));
                qrt_pkg::REG_QUAT_X: quat_x_next = pwdata[qrt_pkg::QUAT_W-1:0];
                qrt_pkg::REG_QUAT_Y: quat_y_next = pwdata[qrt_pkg::QUAT_W-1:0];
                qrt_pkg::REG_QUAT_Z: quat_z_next = pwdata[qrt_pkg::QUAT_W-1:0];
                default:             ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_x_reg  <= '0;
            pos_y_reg  <= '0;
            pos_z_reg  <= '0;
            quat_w_reg <= QUAT_ONE;
            quat_x_reg <= '0;
            quat_y_reg <= '0;
            quat_z_reg <= '0;
        end
        else
        begin
            pos_x_reg  <= pos_x_next;
            pos_y_reg  <= pos_y_next;
            pos_z_reg  <= pos_z_next;
            quat_w_reg <= quat_w_next;
            quat_x_reg <= quat_x_next;
            quat_y_reg <= quat_y_next;
            quat_z_reg <= quat_z_next;
        end
    end

    // Read back, sign-extended
    always_comb
    begin
        case (idx)
            qrt_pkg::REG_POS_X:  prdata = pos_x_reg;
            qrt_pkg::REG_POS_Y:  prdata = pos_y_reg;
            qrt_pkg::REG_POS_Z:  prdata = pos_z_reg;
            qrt_pkg::REG_QUAT_W: prdata = qrt_pkg::DATA_W'($signed(quat_w_reg));
            qrt_pkg::REG_QUAT_X: prdata = qrt_pkg::DATA_W'($signed(quat_x_reg));
            qrt_pkg::REG_QUAT_Y: prdata = qrt_pkg::DATA_W'($signed(quat_y_reg));
            qrt_pkg::REG_QUAT_Z: prdata = qrt_pkg::DATA_W'($signed(quat_z_reg));
            default:             prdata = '0;
        endcase
    end

    // Hand the pose to the datapath
    always_comb
    begin
        cfg.pos_x  = pos_x_reg;
        cfg.pos_y  = pos_y_reg;
        cfg.pos_z  = pos_z_reg;
        cfg.quat_w = qrt_pkg::DATA_W'($signed(quat_w_reg));
        cfg.quat_x = quat_x_reg;
        cfg.quat_y = quat_y_reg;
        cfg.quat_z = quat_z_reg;
    end

endmodule

`default_nettype wire

// ===== sv/qrt_tvec.sv =====
// Two pipeline stages forming t = 2 (u x v), rounded to the coordinate scale.
`timescale 1ns / 1ps
`default_nettype none

module qrt_tvec #(
    parameter int QUAT_FRAC_BITS = qrt_pkg::QUAT_FRAC_BITS_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  qrt_pkg::cfg_t                            cfg,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic                                in_op,
    input  wire logic signed [qrt_pkg::VEC_W-1:0]    in_v [3],
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic                                     out_op,
    output logic signed [qrt_pkg::VEC_W-1:0]         out_v [3],
    output logic signed [qrt_pkg::t_width(QUAT_FRAC_BITS)-1:0] out_t [3]
);

    localparam int UW  = qrt_pkg::UVEC_W;
    localparam int VW  = qrt_pkg::VEC_W;
    localparam int PW  = UW + VW;
    localparam int SW  = PW + 3;
    localparam int TW  = qrt_pkg::t_width(QUAT_FRAC_BITS);
    localparam logic signed [SW-1:0] HALF = SW'(1) << (QUAT_FRAC_BITS - 1);

    logic               a_valid_reg, a_valid_next;
    logic               b_valid_reg, b_valid_next;
    logic               adv_a, adv_b;

    logic               a_op_reg, a_op_next;
    logic signed [VW-1:0] a_v_reg [3];
    logic signed [VW-1:0] a_v_next [3];
    logic signed [PW-1:0] a_pa_reg [3];
    logic signed [PW-1:0] a_pa_next [3];
    logic signed [PW-1:0] a_pb_reg [3];
    logic signed [PW-1:0] a_pb_next [3];

    logic               b_op_reg, b_op_next;
    logic signed [VW-1:0] b_v_reg [3];
    logic signed [VW-1:0] b_v_next [3];
    logic signed [TW-1:0] b_t_reg [3];
    logic signed [TW-1:0] b_t_next [3];

    logic signed [UW-1:0] ux, uy, uz;
    logic signed [UW-1:0] qx, qy, qz;
    logic signed [SW-1:0] tsum [3];

    // Advance a stage when it is empty or its successor moves
    assign adv_b    = !b_valid_reg || out_ready;
    assign adv_a    = !a_valid_reg || adv_b;
    assign in_ready = adv_a;

    // Vector part, negated for the inverse pose
    always_comb
    begin
        qx = UW'($signed(cfg.quat_x));
        qy = UW'($signed(cfg.quat_y));
        qz = UW'($signed(cfg.quat_z));
        ux = (in_op == qrt_pkg::OP_INVERSE) ? -qx : qx;
        uy = (in_op == qrt_pkg::OP_INVERSE) ? -qy : qy;
        uz = (in_op == qrt_pkg::OP_INVERSE) ? -qz : qz;
    end

    // Stage A: cross product terms
    always_comb
    begin
        a_valid_next = adv_a ? in_valid : a_valid_reg;
        a_op_next    = a_op_reg;
        for (int i = 0; i < 3; i++)
        begin
            a_v_next[i]  = a_v_reg[i];
            a_pa_next[i] = a_pa_reg[i];
            a_pb_next[i] = a_pb_reg[i];
        end
        if (adv_a && in_valid)
        begin
            a_op_next    = in_op;
            a_v_next[0]  = in_v[0];
            a_v_next[1]  = in_v[1];
            a_v_next[2]  = in_v[2];
            a_pa_next[0] = uy * in_v[2];
            a_pb_next[0] = uz * in_v[1];
            a_pa_next[1] = uz * in_v[0];
            a_pb_next[1] = ux * in_v[2];
            a_pa_next[2] = ux * in_v[1];
            a_pb_next[2] = uy * in_v[0];
        end
    end

    // Stage B: double, round, rescale
    always_comb
    begin
        b_valid_next = adv_b ? a_valid_reg : b_valid_reg;
        b_op_next    = b_op_reg;
        for (int i = 0; i < 3; i++)
        begin
            tsum[i]     = ((SW'(a_pa_reg[i]) - SW'(a_pb_reg[i])) <<< 1) + HALF;
            b_v_next[i] = b_v_reg[i];
            b_t_next[i] = b_t_reg[i];
        end
        if (adv_b && a_valid_reg)
        begin
            b_op_next = a_op_reg;
            for (int i = 0; i < 3; i++)
            begin
                b_v_next[i] = a_v_reg[i];
                b_t_next[i] = tsum[i][SW-1:QUAT_FRAC_BITS];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_op_reg <= a_op_next;
        b_op_reg <= b_op_next;
        a_v_reg  <= a_v_next;
        a_pa_reg <= a_pa_next;
        a_pb_reg <= a_pb_next;
        b_v_reg  <= b_v_next;
        b_t_reg  <= b_t_next;
    end

    assign out_valid = b_valid_reg;
    assign out_op    = b_op_reg;
    assign out_v     = b_v_reg;
    assign out_t     = b_t_reg;

endmodule

`default_nettype wire

// ===== sv/qrt_rsum.sv =====
// Two pipeline stages forming v + round(w t + u x t), plus the position when forward.
`timescale 1ns / 1ps
`default_nettype none

module qrt_rsum #(
    parameter int QUAT_FRAC_BITS = qrt_pkg::QUAT_FRAC_BITS_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  qrt_pkg::cfg_t                            cfg,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic                                in_op,
    input  wire logic signed [qrt_pkg::VEC_W-1:0]    in_v [3],
    input  wire logic signed [qrt_pkg::t_width(QUAT_FRAC_BITS)-1:0] in_t [3],
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic signed [qrt_pkg::out_width(QUAT_FRAC_BITS)-1:0] out_r [3]
);

    localparam int UW  = qrt_pkg::UVEC_W;
    localparam int VW  = qrt_pkg::VEC_W;
    localparam int QW  = qrt_pkg::quat_w_width(QUAT_FRAC_BITS);
    localparam int TW  = qrt_pkg::t_width(QUAT_FRAC_BITS);
    localparam int PW  = qrt_pkg::mul2_width(QUAT_FRAC_BITS) + TW;
    localparam int SW  = PW + 3;
    localparam int OW  = qrt_pkg::out_width(QUAT_FRAC_BITS);
    localparam logic signed [SW-1:0] HALF = SW'(1) << (QUAT_FRAC_BITS - 1);

    logic               c_valid_reg, c_valid_next;
    logic               d_valid_reg, d_valid_next;
    logic               adv_c, adv_d;

    logic               c_op_reg, c_op_next;
    logic signed [VW-1:0] c_v_reg [3];
    logic signed [VW-1:0] c_v_next [3];
    logic signed [PW-1:0] c_wt_reg [3];
    logic signed [PW-1:0] c_wt_next [3];
    logic signed [PW-1:0] c_pa_reg [3];
    logic signed [PW-1:0] c_pa_next [3];
    logic signed [PW-1:0] c_pb_reg [3];
    logic signed [PW-1:0] c_pb_next [3];

    logic signed [OW-1:0] d_r_reg [3];
    logic signed [OW-1:0] d_r_next [3];

    logic signed [QW-1:0] w;
    logic signed [UW-1:0] ux, uy, uz;
    logic signed [UW-1:0] qx, qy, qz;
    logic signed [SW-1:0] rsum [3];
    logic signed [OW-1:0] pos [3];

    assign adv_d    = !d_valid_reg || out_ready;
    assign adv_c    = !c_valid_reg || adv_d;
    assign in_ready = adv_c;

    // Quaternion, conjugated for the inverse pose
    always_comb
    begin
        w  = $signed(cfg.quat_w[QW-1:0]);
        qx = UW'($signed(cfg.quat_x));
        qy = UW'($signed(cfg.quat_y));
        qz = UW'($signed(cfg.quat_z));
        ux = (in_op == qrt_pkg::OP_INVERSE) ? -qx : qx;
        uy = (in_op == qrt_pkg::OP_INVERSE) ? -qy : qy;
        uz = (in_op == qrt_pkg::OP_INVERSE) ? -qz : qz;
    end

    // Stage C: scalar and cross product terms on t
    always_comb
    begin
        c_valid_next = adv_c ? in_valid : c_valid_reg;
        c_op_next    = c_op_reg;
        for (int i = 0; i < 3; i++)
        begin
            c_v_next[i]  = c_v_reg[i];
            c_wt_next[i] = c_wt_reg[i];
            c_pa_next[i] = c_pa_reg[i];
            c_pb_next[i] = c_pb_reg[i];
        end
        if (adv_c && in_valid)
        begin
            c_op_next    = in_op;
            c_v_next[0]  = in_v[0];
            c_v_next[1]  = in_v[1];
            c_v_next[2]  = in_v[2];
            c_wt_next[0] = w * in_t[0];
            c_wt_next[1] = w * in_t[1];
            c_wt_next[2] = w * in_t[2];
            c_pa_next[0] = uy * in_t[2];
            c_pb_next[0] = uz * in_t[1];
            c_pa_next[1] = uz * in_t[0];
            c_pb_next[1] = ux * in_t[2];
            c_pa_next[2] = ux * in_t[1];
            c_pb_next[2] = uy * in_t[0];
        end
    end

    // Stage D: round, rescale, add v and the forward translation
    always_comb
    begin
        pos[0] = OW'($signed(cfg.pos_x));
        pos[1] = OW'($signed(cfg.pos_y));
        pos[2] = OW'($signed(cfg.pos_z));
        d_valid_next = adv_d ? c_valid_reg : d_valid_reg;
        for (int i = 0; i < 3; i++)
        begin
            rsum[i]     = SW'(c_wt_reg[i]) + SW'(c_pa_reg[i]) - SW'(c_pb_reg[i]) + HALF;
            d_r_next[i] = d_r_reg[i];
            if (adv_d && c_valid_reg)
            begin
                d_r_next[i] = OW'(c_v_reg[i]) + OW'($signed(rsum[i][SW-1:QUAT_FRAC_BITS]))
                            + ((c_op_reg == qrt_pkg::OP_FORWARD) ? pos[i] : '0);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
        end
        else
        begin
            c_valid_reg <= c_valid_next;
            d_valid_reg <= d_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        c_op_reg <= c_op_next;
        c_v_reg  <= c_v_next;
        c_wt_reg <= c_wt_next;
        c_pa_reg <= c_pa_next;
        c_pb_reg <= c_pb_next;
        d_r_reg  <= d_r_next;
    end

    assign out_valid = d_valid_reg;
    assign out_r     = d_r_reg;

endmodule

`default_nettype wire

// ===== sv/quaternion_rigid_transform.sv =====
// Top level: input stage, rotation pipeline, clipping and output register.
`timescale 1ns / 1ps
`default_nettype none

// Applies a rigid pose (unit quaternion in Q2.14 and translation in Q16.16, set
// over APB) to a stream of 3D points. s_tuser selects the forward pose (0) or the
// inverse pose (1). The datapath is a six-stage pipeline: input register with the
// inverse subtraction, two stages for t = 2 (u x v), two for v + w t + u x t with
// the forward translation, and a clipping stage that drives the output register.
// One item is accepted every cycle while m_tready is high; each item passes the
// input register, stages A and B, stages C and D and the output register in turn.
// Each stage holds its item while the stage after it is full, so bubbles are
// absorbed and a stall on the output side reaches the input only once every stage
// is occupied. Results that leave the signed 32-bit range are clipped and flagged
// in m_tuser. Write the pose only while no item is in flight.
module quaternion_rigid_transform #(
    parameter int QUAT_FRAC_BITS = qrt_pkg::QUAT_FRAC_BITS_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    // Configuration
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [qrt_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [qrt_pkg::DATA_W-1:0]  pwdata,
    output logic      [qrt_pkg::DATA_W-1:0]  prdata,
    output logic                             pready,
    // Input points
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    input  wire logic [95:0]                 s_tdata,   // point_x, point_y, point_z
    input  wire logic [0:0]                  s_tuser,   // opcode
    // Results
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    output logic [95:0]                      m_tdata,   // out_x, out_y, out_z
    output logic [0:0]                       m_tuser    // saturated
);

    localparam int CW = qrt_pkg::COORD_W;
    localparam int VW = qrt_pkg::VEC_W;
    localparam int TW = qrt_pkg::t_width(QUAT_FRAC_BITS);
    localparam int OW = qrt_pkg::out_width(QUAT_FRAC_BITS);
    localparam logic signed [OW-1:0] SAT_HI = OW'($signed({1'b0, {(CW-1){1'b1}}}));
    localparam logic signed [OW-1:0] SAT_LO = OW'($signed({1'b1, {(CW-1){1'b0}}}));

    qrt_pkg::cfg_t cfg;

    logic                 s0_valid_reg, s0_valid_next;
    logic                 s0_op_reg, s0_op_next;
    logic signed [VW-1:0] s0_v_reg [3];
    logic signed [VW-1:0] s0_v_next [3];
    logic                 adv_s0;

    logic                 tv_ready, tv_valid, tv_op;
    logic signed [VW-1:0] tv_v [3];
    logic signed [TW-1:0] tv_t [3];

    logic                 rs_ready, rs_valid;
    logic signed [OW-1:0] rs_r [3];

    logic                 e_valid_reg, e_valid_next;
    logic [CW-1:0]        e_out_reg [3];
    logic [CW-1:0]        e_out_next [3];
    logic                 e_sat_reg, e_sat_next;
    logic                 adv_e;

    logic signed [VW-1:0] pt [3];
    logic signed [VW-1:0] ps [3];

    qrt_regs #(
        .QUAT_FRAC_BITS (QUAT_FRAC_BITS)
    ) u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Input stage: subtract the position for the inverse pose
    assign adv_s0   = !s0_valid_reg || tv_ready;
    assign s_tready = adv_s0;

    always_comb
    begin
        pt[0] = VW'($signed(s_tdata[CW-1:0]));
        pt[1] = VW'($signed(s_tdata[2*CW-1:CW]));
        pt[2] = VW'($signed(s_tdata[3*CW-1:2*CW]));
        ps[0] = VW'($signed(cfg.pos_x));
        ps[1] = VW'($signed(cfg.pos_y));
        ps[2] = VW'($signed(cfg.pos_z));
        s0_valid_next = adv_s0 ? s_tvalid : s0_valid_reg;
        s0_op_next    = s0_op_reg;
        for (int i = 0; i < 3; i++)
        begin
            s0_v_next[i] = s0_v_reg[i];
        end
        if (adv_s0 && s_tvalid)
        begin
            s0_op_next = s_tuser[0];
            for (int i = 0; i < 3; i++)
            begin
                s0_v_next[i] = (s_tuser[0] == qrt_pkg::OP_INVERSE) ? pt[i] - ps[i] : pt[i];
            end
        end
    end

    qrt_tvec #(
        .QUAT_FRAC_BITS (QUAT_FRAC_BITS)
    ) u_tvec (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (s0_valid_reg),
        .in_ready  (tv_ready),
        .in_op     (s0_op_reg),
        .in_v      (s0_v_reg),
        .out_valid (tv_valid),
        .out_ready (rs_ready),
        .out_op    (tv_op),
        .out_v     (tv_v),
        .out_t     (tv_t)
    );

    qrt_rsum #(
        .QUAT_FRAC_BITS (QUAT_FRAC_BITS)
    ) u_rsum (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (tv_valid),
        .in_ready  (rs_ready),
        .in_op     (tv_op),
        .in_v      (tv_v),
        .in_t      (tv_t),
        .out_valid (rs_valid),
        .out_ready (adv_e),
        .out_r     (rs_r)
    );

    // Output stage: clip to 32 bits and flag
    assign adv_e = !e_valid_reg || m_tready;

    always_comb
    begin
        e_valid_next = adv_e ? rs_valid : e_valid_reg;
        e_sat_next   = e_sat_reg;
        for (int i = 0; i < 3; i++)
        begin
            e_out_next[i] = e_out_reg[i];
        end
        if (adv_e && rs_valid)
        begin
            e_sat_next = 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                if (rs_r[i] > SAT_HI)
                begin
                    e_out_next[i] = SAT_HI[CW-1:0];
                    e_sat_next    = 1'b1;
                end
                else if (rs_r[i] < SAT_LO)
                begin
                    e_out_next[i] = SAT_LO[CW-1:0];
                    e_sat_next    = 1'b1;
                end
                else
                begin
                    e_out_next[i] = rs_r[i][CW-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
            e_valid_reg  <= 1'b0;
        end
        else
        begin
            s0_valid_reg <= s0_valid_next;
            e_valid_reg  <= e_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s0_op_reg <= s0_op_next;
        s0_v_reg  <= s0_v_next;
        e_out_reg <= e_out_next;
        e_sat_reg <= e_sat_next;
    end

    assign m_tvalid   = e_valid_reg;
    assign m_tdata    = {e_out_reg[2], e_out_reg[1], e_out_reg[0]};
    assign m_tuser[0] = e_sat_reg;

endmodule

`default_nettype wire

// ===== sv/qrt_checker.sv =====
// Port-level checks for the quaternion rigid transform, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module qrt_checker (
    input wire logic                        clk,
    input wire logic                        rst_n,
    input wire logic                        s_tready,
    input wire logic                        m_tvalid,
    input wire logic                        m_tready,
    input wire logic [95:0]                 m_tdata,
    input wire logic [0:0]                  m_tuser
);

    localparam logic [31:0] MAXV = 32'h7FFF_FFFF;
    localparam logic [31:0] MINV = 32'h8000_0000;

    // Reset leaves the pipeline empty
    a_reset_empty: assert property (@(posedge clk) $rose(rst_n) |-> !m_tvalid)
        else $error("result valid right after reset");

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // A flowing output side never back-pressures the input
    a_flow: assert property (@(posedge clk) disable iff (!rst_n) m_tready |-> s_tready)
        else $error("input stalled while output drains");

    // A clipped result carries a limit value in some coordinate
    a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |->
            (m_tdata[31:0] == MAXV) || (m_tdata[31:0] == MINV) ||
            (m_tdata[63:32] == MAXV) || (m_tdata[63:32] == MINV) ||
            (m_tdata[95:64] == MAXV) || (m_tdata[95:64] == MINV))
        else $error("saturated flag without a clipped coordinate");

endmodule

bind quaternion_rigid_transform qrt_checker u_qrt_checker (.*);

`default_nettype wire
